### hw/rtl/pscc_pkg.sv
`default_nettype none

package pscc_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GAIN_P         = 3'd0,
      CSR_GAIN_I         = 3'd1,
      CSR_GAIN_D         = 3'd2,
      CSR_SLEW_LIMIT     = 3'd3,
      CSR_SMALL_BAND     = 3'd4,
      CSR_SMALL_DWELL_MS = 3'd5,
      CSR_LARGE_BAND     = 3'd6,
      CSR_LARGE_DWELL_MS = 3'd7
   } csr_index_type;

   localparam logic [CSR_DATA_WIDTH-1:0] GAIN_P_RESET = 16'd256;

   typedef struct packed {
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [15:0] slew_limit;
      logic [15:0] small_band;
      logic [15:0] small_dwell_ms;
      logic [15:0] large_band;
      logic [15:0] large_dwell_ms;
   } cfg_type;

   typedef enum logic [1:0] {
      CAUSE_NONE    = 2'd0,
      CAUSE_TIMEOUT = 2'd1,
      CAUSE_LARGE   = 2'd2,
      CAUSE_SMALL   = 2'd3
   } cause_type;

   typedef struct packed {
      logic commit;
      logic restart;
   } step_ctl_type;

endpackage

`default_nettype wire

### hw/rtl/pscc_req_if.sv
`default_nettype none

interface pscc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] setpoint;
   logic signed [15:0] measured;
   logic        [7:0]  elapsed_ms;
   logic               restart;

   modport source (output valid, output setpoint, output measured, output elapsed_ms,
                   output restart, input ready);
   modport sink   (input valid, input setpoint, input measured, input elapsed_ms,
                   input restart, output ready);
endinterface

`default_nettype wire

### hw/rtl/pscc_rsp_if.sv
`default_nettype none

interface pscc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] drive;
   logic               is_settled;
   logic        [1:0]  exit_cause;

   modport source (output valid, output drive, output is_settled, output exit_cause,
                   input ready);
   modport sink   (input valid, input drive, input is_settled, input exit_cause,
                   output ready);
endinterface

`default_nettype wire

### hw/rtl/pid_slew_settle_controller_core.sv
`default_nettype none

// PID position controller with slew limiting and settle detection. One request transfer
// carries a setpoint, a measurement, the milliseconds since the previous request and a
// restart flag; each produces exactly one response transfer with the saturated drive and
// the settle status. A request is registered in the input register on acceptance and is
// processed from there into the output register once that register can take its response,
// where the response is held until it is taken. While the receiver keeps up the
// block accepts one request every cycle: the controller history and the settle timers are
// updated in the same cycle as the response register, through three 17-bit by up to 32-bit
// multipliers, an adder, the saturation and the slew clamp. The user must write configuration
// registers through the csr port only while no transfer is in flight; the block does not enforce this.
module pid_slew_settle_controller_core #(
   parameter int unsigned TIMEOUT_MS = 5000
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   pscc_req_if.sink                                      req_chan,
   pscc_rsp_if.source                                    rsp_chan,
   input  wire logic                                     csr_wr_en,
   input  wire logic [pscc_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [pscc_pkg::CSR_DATA_WIDTH-1:0]      csr_wr_data
);

   pscc_pkg::cfg_type      cfg_ff, cfg_in;
   pscc_pkg::cfg_type      cfg_reset;
   pscc_pkg::step_ctl_type step;
   pscc_pkg::cause_type    cause;

   logic               in_valid_ff, in_valid_in;
   logic signed [15:0] in_setpoint_ff;
   logic signed [15:0] in_measured_ff;
   logic        [7:0]  in_elapsed_ms_ff;
   logic               in_restart_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_drive_ff;
   logic        [1:0]  rsp_exit_cause_ff;

   logic               advance;
   logic               commit;
   logic signed [16:0] error;
   logic signed [15:0] drive;

   // The proportional gain is the leading field; every other register resets to zero.
   assign cfg_reset = {pscc_pkg::GAIN_P_RESET,
                       {($bits(pscc_pkg::cfg_type) - pscc_pkg::CSR_DATA_WIDTH){1'b0}}};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pscc_pkg::CSR_GAIN_P:         cfg_in.gain_p         = csr_wr_data;
            pscc_pkg::CSR_GAIN_I:         cfg_in.gain_i         = csr_wr_data;
            pscc_pkg::CSR_GAIN_D:         cfg_in.gain_d         = csr_wr_data;
            pscc_pkg::CSR_SLEW_LIMIT:     cfg_in.slew_limit     = csr_wr_data;
            pscc_pkg::CSR_SMALL_BAND:     cfg_in.small_band     = csr_wr_data;
            pscc_pkg::CSR_SMALL_DWELL_MS: cfg_in.small_dwell_ms = csr_wr_data;
            pscc_pkg::CSR_LARGE_BAND:     cfg_in.large_band     = csr_wr_data;
            pscc_pkg::CSR_LARGE_DWELL_MS: cfg_in.large_dwell_ms = csr_wr_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cfg_reset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The held request is processed whenever the output register can take its response.
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign commit         = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
   assign rsp_valid_in = commit ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_setpoint_ff   <= req_chan.setpoint;
         in_measured_ff   <= req_chan.measured;
         in_elapsed_ms_ff <= req_chan.elapsed_ms;
         in_restart_ff    <= req_chan.restart;
      end
      if (commit) begin
         rsp_drive_ff      <= drive;
         rsp_exit_cause_ff <= cause;
      end
   end

   assign step.commit  = commit;
   assign step.restart = in_restart_ff;

   assign error = $signed({in_setpoint_ff[15], in_setpoint_ff})
                - $signed({in_measured_ff[15], in_measured_ff});

   pscc_law u_law (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .cfg   (cfg_ff),
      .error (error),
      .drive (drive)
   );

   pscc_settle #(
      .TIMEOUT_MS (TIMEOUT_MS)
   ) u_settle (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cfg        (cfg_ff),
      .error      (error),
      .elapsed_ms (in_elapsed_ms_ff),
      .cause      (cause)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.drive      = rsp_drive_ff;
   assign rsp_chan.exit_cause = rsp_exit_cause_ff;
   assign rsp_chan.is_settled = (rsp_exit_cause_ff != pscc_pkg::CAUSE_NONE);

   a_commit_gives_response : assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("processed request did not reach the output register");

   a_restart_not_settled : assert property (@(posedge clock) disable iff (reset)
      (commit && in_restart_ff) |=> (rsp_exit_cause_ff == pscc_pkg::CAUSE_NONE))
      else $error("first response after restart reports a settle exit");

   a_request_held : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_setpoint_ff)
                                     && $stable(in_restart_ff)))
      else $error("held request lost while the output was stalled");

endmodule

`default_nettype wire

### hw/rtl/pscc_law.sv
`default_nettype none

module pscc_law (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pscc_pkg::step_ctl_type step,
   input  wire pscc_pkg::cfg_type     cfg,
   input  wire logic signed [16:0]    error,
   output logic signed [15:0]         drive
);

   logic signed [16:0] last_error_ff, last_error_in;
   logic signed [31:0] error_sum_ff, error_sum_in;
   logic signed [15:0] last_drive_ff, last_drive_in;

   logic signed [16:0] base_error;
   logic signed [31:0] prev_sum;
   logic signed [15:0] prev_drive;
   logic signed [17:0] delta;
   logic signed [33:0] prod_p;
   logic signed [48:0] prod_i;
   logic signed [34:0] prod_d;
   logic signed [49:0] acc;
   logic signed [41:0] scaled;
   logic signed [17:0] sat_drive;
   logic signed [17:0] slew_lo;
   logic signed [17:0] slew_hi;
   logic signed [17:0] slewed;
   logic signed [32:0] sum_wide;

   // A restart item sees cleared history.
   assign base_error = step.restart ? '0 : last_error_ff;
   assign prev_sum   = step.restart ? '0 : error_sum_ff;
   assign prev_drive = step.restart ? '0 : last_drive_ff;

   assign delta  = $signed({error[16], error}) - $signed({base_error[16], base_error});
   assign prod_p = 34'($signed({1'b0, cfg.gain_p})) * 34'(error);
   assign prod_i = 49'($signed({1'b0, cfg.gain_i})) * 49'(prev_sum);
   assign prod_d = 35'($signed({1'b0, cfg.gain_d})) * 35'(delta);

   assign acc = $signed({{16{prod_p[33]}}, prod_p})
              + $signed({{1{prod_i[48]}}, prod_i})
              + $signed({{15{prod_d[34]}}, prod_d});

   // Dropping the eight fraction bits of a two's complement value rounds down.
   assign scaled = acc[49:8];

   always_comb begin
      if (scaled > 42'sd32767) begin
         sat_drive = 18'sd32767;
      end else if (scaled < -42'sd32768) begin
         sat_drive = -18'sd32768;
      end else begin
         sat_drive = scaled[17:0];
      end
   end

   assign slew_lo = $signed({{2{prev_drive[15]}}, prev_drive}) - $signed({2'b00, cfg.slew_limit});
   assign slew_hi = $signed({{2{prev_drive[15]}}, prev_drive}) + $signed({2'b00, cfg.slew_limit});

   always_comb begin
      if (cfg.slew_limit == '0) begin
         slewed = sat_drive;
      end else if (sat_drive < slew_lo) begin
         slewed = slew_lo;
      end else if (sat_drive > slew_hi) begin
         slewed = slew_hi;
      end else begin
         slewed = sat_drive;
      end
   end

   assign drive = slewed[15:0];

   assign sum_wide = $signed({prev_sum[31], prev_sum}) + $signed({{16{error[16]}}, error});

   always_comb begin
      last_error_in = last_error_ff;
      error_sum_in  = error_sum_ff;
      last_drive_in = last_drive_ff;
      if (step.commit) begin
         last_error_in = error;
         last_drive_in = drive;
         if (sum_wide[32] != sum_wide[31]) begin
            error_sum_in = sum_wide[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
         end else begin
            error_sum_in = sum_wide[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         error_sum_ff  <= '0;
         last_drive_ff <= '0;
      end else begin
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
         last_drive_ff <= last_drive_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/pscc_settle.sv
`default_nettype none

module pscc_settle #(
   parameter int unsigned TIMEOUT_MS = 5000
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pscc_pkg::step_ctl_type step,
   input  wire pscc_pkg::cfg_type      cfg,
   input  wire logic signed [16:0]     error,
   input  wire logic [7:0]             elapsed_ms,
   output pscc_pkg::cause_type         cause
);

   logic [31:0] run_clock_ff, run_clock_in;
   logic        started_ff, started_in;
   logic [31:0] large_since_ff, large_since_in;
   logic        large_armed_ff, large_armed_in;
   logic [31:0] small_since_ff, small_since_in;
   logic        small_armed_ff, small_armed_in;

   logic [31:0] prev_clock;
   logic        prev_started;
   logic [31:0] prev_large_since;
   logic        prev_large_armed;
   logic [31:0] prev_small_since;
   logic        prev_small_armed;
   logic [16:0] mag;
   logic [32:0] clock_sum;
   logic [31:0] run_next;
   logic        in_large;
   logic        in_small;
   logic        timeout_hit;
   logic        large_hit;
   logic        small_hit;

   assign prev_clock       = step.restart ? '0 : run_clock_ff;
   assign prev_started     = step.restart ? 1'b0 : started_ff;
   assign prev_large_since = step.restart ? '0 : large_since_ff;
   assign prev_large_armed = step.restart ? 1'b0 : large_armed_ff;
   assign prev_small_since = step.restart ? '0 : small_since_ff;
   assign prev_small_armed = step.restart ? 1'b0 : small_armed_ff;

   assign mag = error[16] ? 17'(-error) : 17'(error);

   // The clock starts at zero on the first item and saturates at its top value.
   assign clock_sum = {1'b0, prev_clock} + {25'd0, elapsed_ms};
   assign run_next  = !prev_started ? '0 : (clock_sum[32] ? '1 : clock_sum[31:0]);

   assign in_large = prev_started && (mag < {1'b0, cfg.large_band});
   assign in_small = prev_started && (mag < {1'b0, cfg.small_band});

   assign timeout_hit = prev_started && (run_next > 32'(TIMEOUT_MS));
   assign large_hit   = in_large && prev_large_armed
                        && ((run_next - prev_large_since) > {16'd0, cfg.large_dwell_ms});
   assign small_hit   = in_small && prev_small_armed
                        && ((run_next - prev_small_since) > {16'd0, cfg.small_dwell_ms});

   always_comb begin
      if (timeout_hit) begin
         cause = pscc_pkg::CAUSE_TIMEOUT;
      end else if (large_hit) begin
         cause = pscc_pkg::CAUSE_LARGE;
      end else if (small_hit) begin
         cause = pscc_pkg::CAUSE_SMALL;
      end else begin
         cause = pscc_pkg::CAUSE_NONE;
      end
   end

   always_comb begin
      run_clock_in   = run_clock_ff;
      started_in     = started_ff;
      large_since_in = large_since_ff;
      large_armed_in = large_armed_ff;
      small_since_in = small_since_ff;
      small_armed_in = small_armed_ff;
      if (step.commit) begin
         run_clock_in   = run_next;
         started_in     = 1'b1;
         large_since_in = prev_large_since;
         large_armed_in = prev_large_armed;
         small_since_in = prev_small_since;
         small_armed_in = prev_small_armed;
         if (in_large && !prev_large_armed) begin
            large_armed_in = 1'b1;
            large_since_in = run_next;
         end
         if (in_small && !prev_small_armed) begin
            small_armed_in = 1'b1;
            small_since_in = run_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_clock_ff   <= '0;
         started_ff     <= 1'b0;
         large_since_ff <= '0;
         large_armed_ff <= 1'b0;
         small_since_ff <= '0;
         small_armed_ff <= 1'b0;
      end else begin
         run_clock_ff   <= run_clock_in;
         started_ff     <= started_in;
         large_since_ff <= large_since_in;
         large_armed_ff <= large_armed_in;
         small_since_ff <= small_since_in;
         small_armed_ff <= small_armed_in;
      end
   end

endmodule

`default_nettype wire

### test/tb_pid_slew_settle_controller_core.sv
module tb_pid_slew_settle_controller_core;

   localparam int unsigned TIMEOUT_MS        = 5000;
   localparam int          WATCHDOG_LIMIT    = 2000;
   localparam int          LONG_STALL_CYCLES = 150;
   localparam int          PHASE_ITEMS       = 160;
   localparam int          SOAK_ITEMS        = 40;

   typedef struct {
      logic signed [15:0]  drive;
      logic                settled;
      pscc_pkg::cause_type cause;
   } controller_output_type;

   class drive_predictor_type;
      pscc_pkg::cfg_type     cfg;
      logic signed [16:0]    last_err;
      logic signed [31:0]    error_total;
      logic signed [15:0]    prev_drive;
      logic [31:0]           clock_ms;
      bit                    clock_running;
      logic [31:0]           large_start;
      bit                    large_running;
      logic [31:0]           small_start;
      bit                    small_running;
      int unsigned           timeout_ms;
      int                    mismatches;
      controller_output_type awaited_outputs[$];

      function new(int unsigned timeout_ms_init);
         timeout_ms = timeout_ms_init;
         mismatches = 0;
         cfg = '0;
         cfg.gain_p = pscc_pkg::GAIN_P_RESET;
         clear_history();
      endfunction

      function void clear_history();
         last_err = '0;
         error_total = '0;
         prev_drive = '0;
         clock_ms = '0;
         clock_running = 1'b0;
         large_start = '0;
         large_running = 1'b0;
         small_start = '0;
         small_running = 1'b0;
      endfunction

      function void set_register(pscc_pkg::csr_index_type idx, logic [15:0] value);
         case (idx)
            pscc_pkg::CSR_GAIN_P:         cfg.gain_p = value;
            pscc_pkg::CSR_GAIN_I:         cfg.gain_i = value;
            pscc_pkg::CSR_GAIN_D:         cfg.gain_d = value;
            pscc_pkg::CSR_SLEW_LIMIT:     cfg.slew_limit = value;
            pscc_pkg::CSR_SMALL_BAND:     cfg.small_band = value;
            pscc_pkg::CSR_SMALL_DWELL_MS: cfg.small_dwell_ms = value;
            pscc_pkg::CSR_LARGE_BAND:     cfg.large_band = value;
            pscc_pkg::CSR_LARGE_DWELL_MS: cfg.large_dwell_ms = value;
            default: ;
         endcase
      endfunction

      function void note_request(logic signed [15:0] setpoint, logic signed [15:0] measured,
                                 logic [7:0] elapsed_ms, logic restart);
         longint                err;
         longint                delta;
         longint                acc;
         longint                drv;
         longint                mag;
         longint                total;
         logic [31:0]           dwell;
         pscc_pkg::cause_type   cause;
         controller_output_type result;
         if (restart) begin
            clear_history();
         end
         err = longint'(setpoint) - longint'(measured);
         delta = err - longint'(last_err);
         acc = longint'(cfg.gain_p) * err + longint'(cfg.gain_i) * longint'(error_total)
             + longint'(cfg.gain_d) * delta;
         drv = acc >>> 8;
         if (drv < -32768) drv = -32768;
         if (drv > 32767) drv = 32767;
         if (cfg.slew_limit != 0) begin
            if (drv < longint'(prev_drive) - longint'(cfg.slew_limit)) begin
               drv = longint'(prev_drive) - longint'(cfg.slew_limit);
            end
            if (drv > longint'(prev_drive) + longint'(cfg.slew_limit)) begin
               drv = longint'(prev_drive) + longint'(cfg.slew_limit);
            end
         end
         prev_drive = drv[15:0];
         last_err = err[16:0];
         total = longint'(error_total) + err;
         if (total > 64'sd2147483647) total = 64'sd2147483647;
         if (total < -64'sd2147483648) total = -64'sd2147483648;
         error_total = total[31:0];
         mag = (err < 0) ? -err : err;
         cause = pscc_pkg::CAUSE_NONE;
         if (!clock_running) begin
            clock_running = 1'b1;
            clock_ms = '0;
         end else begin
            if (clock_ms > 32'hFFFF_FFFF - {24'd0, elapsed_ms}) begin
               clock_ms = 32'hFFFF_FFFF;
            end else begin
               clock_ms = clock_ms + {24'd0, elapsed_ms};
            end
            if (clock_ms > timeout_ms) begin
               cause = pscc_pkg::CAUSE_TIMEOUT;
            end
            if (mag < longint'(cfg.large_band)) begin
               dwell = clock_ms - large_start;
               if (!large_running) begin
                  large_running = 1'b1;
                  large_start = clock_ms;
               end else if (dwell > {16'd0, cfg.large_dwell_ms}
                            && cause == pscc_pkg::CAUSE_NONE) begin
                  cause = pscc_pkg::CAUSE_LARGE;
               end
            end
            if (mag < longint'(cfg.small_band)) begin
               dwell = clock_ms - small_start;
               if (!small_running) begin
                  small_running = 1'b1;
                  small_start = clock_ms;
               end else if (dwell > {16'd0, cfg.small_dwell_ms}
                            && cause == pscc_pkg::CAUSE_NONE) begin
                  cause = pscc_pkg::CAUSE_SMALL;
               end
            end
         end
         result.drive = drv[15:0];
         result.settled = (cause != pscc_pkg::CAUSE_NONE);
         result.cause = cause;
         awaited_outputs.push_back(result);
      endfunction

      function void check_response(logic signed [15:0] drive, logic settled, logic [1:0] cause);
         controller_output_type want;
         if (awaited_outputs.size() == 0) begin
            $error("response transfer with no request outstanding: drive %0d", drive);
            mismatches++;
            return;
         end
         want = awaited_outputs.pop_front();
         if (drive !== want.drive) begin
            $error("drive: expected %0d, actual %0d", want.drive, drive);
            mismatches++;
         end
         if (settled !== want.settled) begin
            $error("is_settled: expected %0b, actual %0b", want.settled, settled);
            mismatches++;
         end
         if (cause !== want.cause) begin
            $error("exit_cause: expected %0d, actual %0d", want.cause, cause);
            mismatches++;
         end
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 csr_wr_en;
   logic [pscc_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [pscc_pkg::CSR_DATA_WIDTH-1:0]  csr_wr_data;

   pscc_req_if req_chan();
   pscc_rsp_if rsp_chan();

   drive_predictor_type predictor;
   bit                  sender_idles;
   bit                  receiver_idles;
   bit                  stall_request;
   int                  sent_count;
   int                  quiet_cycles;

   pid_slew_settle_controller_core #(
      .TIMEOUT_MS(TIMEOUT_MS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("FAIL pid_slew_settle_controller_core");
               $finish;
            end
         end
      end
   end

   initial begin : receiver
      int gap;
      @(negedge reset);
      forever begin
         if (stall_request) begin
            gap = LONG_STALL_CYCLES;
            stall_request = 1'b0;
         end else begin
            gap = receiver_idles ? int'($urandom_range(0, 11)) : 0;
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         predictor.check_response(rsp_chan.drive, rsp_chan.is_settled, rsp_chan.exit_cause);
      end
   end

   task automatic send_request(logic signed [15:0] setpoint, logic signed [15:0] measured,
                               logic [7:0] elapsed_ms, logic restart);
      int gap;
      gap = sender_idles ? int'($urandom_range(0, 11)) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.setpoint <= setpoint;
      req_chan.measured <= measured;
      req_chan.elapsed_ms <= elapsed_ms;
      req_chan.restart <= restart;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sent_count++;
      predictor.note_request(setpoint, measured, elapsed_ms, restart);
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (predictor.awaited_outputs.size() != 0) @(posedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic put_register(pscc_pkg::csr_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      predictor.set_register(idx, value);
   endtask

   task automatic write_config(pscc_pkg::cfg_type c);
      drain();
      put_register(pscc_pkg::CSR_GAIN_P, c.gain_p);
      put_register(pscc_pkg::CSR_GAIN_I, c.gain_i);
      put_register(pscc_pkg::CSR_GAIN_D, c.gain_d);
      put_register(pscc_pkg::CSR_SLEW_LIMIT, c.slew_limit);
      put_register(pscc_pkg::CSR_SMALL_BAND, c.small_band);
      put_register(pscc_pkg::CSR_SMALL_DWELL_MS, c.small_dwell_ms);
      put_register(pscc_pkg::CSR_LARGE_BAND, c.large_band);
      put_register(pscc_pkg::CSR_LARGE_DWELL_MS, c.large_dwell_ms);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [15:0] pick_setting(int unsigned typical);
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, typical));
      endcase
   endfunction

   // A run starts from a random target and converges on it, so that the band
   // timers arm and the dwell exits are reached before the overall timeout.
   task automatic settle_sequence(int len);
      int         target;
      int         offset;
      int         position;
      logic [7:0] elapsed;
      bit         fresh;
      target = int'($urandom_range(0, 65535)) - 32768;
      offset = int'($urandom_range(0, 8000)) - 4000;
      fresh = ($urandom_range(0, 7) != 0);
      for (int i = 0; i < len; i++) begin
         position = target - offset;
         if (position > 32767) position = 32767;
         if (position < -32768) position = -32768;
         elapsed = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 40));
         send_request(16'(target), 16'(position), elapsed, fresh && i == 0);
         offset = offset * int'($urandom_range(50, 95)) / 100
                + int'($urandom_range(0, 6)) - 3;
      end
   endtask

   task automatic noise_request();
      send_request(16'($urandom), 16'($urandom), 8'($urandom), $urandom_range(0, 15) == 0);
   endtask

   initial begin : stimulus
      pscc_pkg::cfg_type c;
      int                target_count;
      predictor = new(TIMEOUT_MS);
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = pscc_pkg::CSR_GAIN_P;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.setpoint = '0;
      req_chan.measured = '0;
      req_chan.elapsed_ms = '0;
      req_chan.restart = 1'b0;
      rsp_chan.ready = 1'b0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      stall_request = 1'b0;
      sent_count = 0;
      quiet_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The first transfer after reset runs on the reset gains.
      send_request(16'sd100, -16'sd20, 8'd7, 1'b0);

      c = '0;
      c.gain_p = 16'd256;
      c.small_band = 16'd10;
      c.small_dwell_ms = 16'd5;
      c.large_band = 16'd1000;
      c.large_dwell_ms = 16'd100;
      write_config(c);
      send_request(16'sd0, 16'sd0, 8'd0, 1'b1);
      send_request(16'sd600, 16'sd100, 8'd3, 1'b0);
      send_request(16'sd5, 16'sd0, 8'd3, 1'b0);
      send_request(16'sd0, -16'sd5, 8'd10, 1'b0);
      send_request(16'sd2000, 16'sd0, 8'd200, 1'b0);
      repeat (18) send_request(16'sh8000, 16'sh7FFF, 8'd255, 1'b0);
      send_request(16'sh7FFF, 16'sh8000, 8'd255, 1'b0);

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: c = '1;
            1: c = '0;
            2: begin
               c = '0;
               c.gain_p = pscc_pkg::GAIN_P_RESET;
            end
            default: begin
               c.gain_p = pick_setting(1024);
               c.gain_i = pick_setting(64);
               c.gain_d = pick_setting(1024);
               c.slew_limit = pick_setting(2000);
               c.small_band = pick_setting(200);
               c.small_dwell_ms = pick_setting(300);
               c.large_band = pick_setting(3000);
               c.large_dwell_ms = pick_setting(600);
            end
         endcase
         write_config(c);
         sender_idles = (phase == 0) || ($urandom_range(0, 3) != 0);
         receiver_idles = (phase == 0) || ($urandom_range(0, 3) != 0);
         if (phase == 4) begin
            stall_request = 1'b1;
            sender_idles = 1'b0;
            settle_sequence(24);
            sender_idles = 1'b1;
         end
         target_count = sent_count + PHASE_ITEMS;
         while (sent_count < target_count) begin
            if ($urandom_range(0, 3) != 0) begin
               settle_sequence(int'($urandom_range(5, 40)));
            end else begin
               repeat ($urandom_range(1, 5)) noise_request();
            end
         end
      end

      // Runs at the largest error of each sign build a large error sum with only the integral
      // gain set, so that the integral term alone drives the output.
      c = '0;
      c.gain_i = 16'd1;
      write_config(c);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      for (int i = 0; i < SOAK_ITEMS; i++) begin
         send_request(16'sh7FFF, 16'sh8000, 8'($urandom), i == 0);
      end
      for (int i = 0; i < SOAK_ITEMS; i++) begin
         send_request(16'sh8000, 16'sh7FFF, 8'($urandom), i == 0);
      end

      drain();
      if (predictor.mismatches == 0) begin
         $display("PASS pid_slew_settle_controller_core");
      end else begin
         $display("FAIL pid_slew_settle_controller_core");
      end
      $finish;
   end
endmodule
